>>> design/set_assoc_tlb_lru_lookup_unit_macros.svh
// Assertion macros shared by the checker of the TLB lookup unit.
// Needs a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef SET_ASSOC_TLB_LRU_LOOKUP_UNIT_MACROS_SVH
`define SET_ASSOC_TLB_LRU_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SATL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed number of cycles between antecedent and consequent.
`define SATL_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

>>> design/satl_pkg.sv
// Shared widths, access-bit codes and configuration register indexes of the
// TLB lookup unit. No dependencies.
package satl_pkg;

  localparam int PAGE_SHIFT_W    = 5;
  localparam int INDEX_SKIP_W    = 5;
  localparam int CLUSTER_SHIFT_W = 4;
  localparam int WAY_OUT_W       = 2;
  localparam int ACC_W           = 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 5;

  // Page shift plus cluster shift stays below 64; adding the index skip stays below 128.
  localparam int SHIFT_W     = PAGE_SHIFT_W + 1;
  localparam int SET_SHIFT_W = SHIFT_W + 1;

  // Access bits: bit 1 accessed, bit 0 dirty.
  localparam logic [ACC_W-1:0] ACC_READ  = 2'b10;
  localparam logic [ACC_W-1:0] ACC_WRITE = 2'b11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SECOND_LEVEL_MODE = 2'd0,
    CFG_INDEX_SKIP        = 2'd1,
    CFG_CLUSTER_SHIFT     = 2'd2
  } cfg_reg_e;

endpackage

>>> design/set_assoc_tlb_lru_lookup_unit.sv
// One level of a set-associative data TLB with saturating age-stamp
// replacement. The unit takes one access per clock cycle, every cycle: busy
// stays low and start alone decides. Each access produces exactly one result,
// shown for a single cycle with done_o high. Between acceptance and result
// an access passes the input register, the address shifter, the two-stage
// set-index reduction, the registered read of the set memory and the result
// register; the set memory's single read port is used once per access, which
// is what holds the rate at one access per cycle. The receiver cannot stall
// the results, so results must be taken when done_o is high. Entry valid bits
// live in flip-flops cleared by reset, so no clearing pass follows reset.
// Configuration is written through a separate channel whose ready is always
// high; it should only be changed while no access is in flight.
//
// Top level: pipeline, configuration registers and per-set update logic.
// Depends on satl_pkg, satl_set_index and satl_ram.
module set_assoc_tlb_lru_lookup_unit
  import satl_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int VADDR_BITS = 48,
  parameter int AGE_BITS   = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [VADDR_BITS-1:0]   virt_addr_i,
  input  logic                    is_write_i,
  input  logic [PAGE_SHIFT_W-1:0] page_shift_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [WAY_OUT_W-1:0]    way_o,
  output logic [ACC_W-1:0]        access_bits_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  // The tag keeps every bit of the shifted address plus the type bit that the
  // second-level mode appends below it, clipped to 64 bits.
  localparam int TAG_W     = (VADDR_BITS < 64) ? VADDR_BITS + 1 : 64;
  localparam int TREE_LVLS = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int TREE_N    = 1 << TREE_LVLS;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [AGE_BITS-1:0] age;
    logic [ACC_W-1:0]    bits;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes beyond the register list are dropped.
  // ---------------------------------------------------------------------------
  logic                       mode_q;
  logic [INDEX_SKIP_W-1:0]    skip_q;
  logic [CLUSTER_SHIFT_W-1:0] cluster_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      skip_q    <= '0;
      cluster_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SECOND_LEVEL_MODE: mode_q    <= cfg_data_i[0];
        CFG_INDEX_SKIP:        skip_q    <= cfg_data_i[INDEX_SKIP_W-1:0];
        CFG_CLUSTER_SHIFT:     cluster_q <= cfg_data_i[CLUSTER_SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits. Nothing ever stalls, so each stage simply follows the
  // one before it.
  // ---------------------------------------------------------------------------
  logic accept;
  logic s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic done_q;
  logic fwd_vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s0_vld_q  <= accept;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      done_q    <= s3_vld_q;
      fwd_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------
  logic [VADDR_BITS-1:0]   s0_addr_q;
  logic                    s0_wr_q;
  logic [PAGE_SHIFT_W-1:0] s0_pshift_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_addr_q   <= virt_addr_i;
      s0_wr_q     <= is_write_i;
      s0_pshift_q <= page_shift_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0 to 1: shift amounts, tag and set-index source. A shift by the
  // address width or more yields zero, as it should for huge page sizes.
  // ---------------------------------------------------------------------------
  logic [SHIFT_W-1:0]     shamt;
  logic [SET_SHIFT_W-1:0] set_shamt;
  logic [VADDR_BITS-1:0]  tag_src;
  logic [VADDR_BITS-1:0]  set_src;
  logic [TAG_W-1:0]       tag_d;

  always_comb begin
    shamt     = SHIFT_W'(s0_pshift_q) + SHIFT_W'(cluster_q);
    set_shamt = mode_q ? SET_SHIFT_W'(shamt) + SET_SHIFT_W'(skip_q) : SET_SHIFT_W'(shamt);
    tag_src   = s0_addr_q >> shamt;
    set_src   = s0_addr_q >> set_shamt;
    // Second-level entries carry a type bit of zero below the tag.
    tag_d     = mode_q ? TAG_W'({tag_src, 1'b0}) : TAG_W'({1'b0, tag_src});
  end

  // The set index comes out of the registered reduction aligned with stage 2.
  logic [IDX_W-1:0] set_s2;

  satl_set_index #(
    .SRC_W(VADDR_BITS),
    .SETS (SETS)
  ) u_set_index (
    .clk_i(clk_i),
    .src_i(set_src),
    .set_o(set_s2)
  );

  logic [TAG_W-1:0] s1_tag_q, s2_tag_q, s3_tag_q;
  logic             s1_wr_q, s2_wr_q, s3_wr_q;
  logic [IDX_W-1:0] s3_set_q;

  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag_d;
    s1_wr_q  <= s0_wr_q;
    s2_tag_q <= s1_tag_q;
    s2_wr_q  <= s1_wr_q;
    s3_tag_q <= s2_tag_q;
    s3_wr_q  <= s2_wr_q;
    s3_set_q <= set_s2;
  end

  // ---------------------------------------------------------------------------
  // Set memory: one row per set holding tag, age stamp and access bits of every
  // way. The read for an access is issued in stage 2 and its data is used in
  // stage 3, where the row is written back at the end of the cycle.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] ram_rdata;
  row_t             new_row;

  satl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (s3_vld_q),
    .waddr_i(s3_set_q),
    .wdata_i(new_row),
    .raddr_i(set_s2),
    .rdata_o(ram_rdata)
  );

  // The access directly ahead writes its row at the same edge at which this
  // access reads it, so that row is held in a register and forwarded when the
  // sets match. Older writes are already in the memory.
  logic [IDX_W-1:0] fwd_set_q;
  row_t             fwd_row_q;

  always_ff @(posedge clk_i) begin
    fwd_set_q <= s3_set_q;
    fwd_row_q <= new_row;
  end

  // Valid bits per entry, cleared by reset. They are updated at the write edge
  // and read directly by the next access, so they need no forwarding.
  logic [WAYS-1:0] valid_q [SETS];
  logic [WAYS-1:0] vld_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (s3_vld_q) begin
      valid_q[s3_set_q] <= vld_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: tag compare, free-way search, victim choice and row update.
  // ---------------------------------------------------------------------------
  row_t              row_cur;
  logic [WAYS-1:0]   vld_cur;
  logic [ACC_W-1:0]  acc_set;
  logic              hit_any;
  logic [WIDX_W-1:0] hit_way;
  logic              free_any;
  logic [WIDX_W-1:0] free_way;
  logic [WIDX_W-1:0] victim_way;
  logic [WIDX_W-1:0] sel_way;
  logic [ACC_W-1:0]  acc_new;

  always_comb begin
    row_cur  = (fwd_vld_q && (fwd_set_q == s3_set_q)) ? fwd_row_q : row_t'(ram_rdata);
    vld_cur  = valid_q[s3_set_q];
    acc_set  = s3_wr_q ? ACC_WRITE : ACC_READ;
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    // Scanning from the top leaves the lowest matching way selected.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_cur[w] && (row_cur[w].tag == s3_tag_q)) begin
        hit_any = 1'b1;
        hit_way = WIDX_W'(w);
      end
      if (!vld_cur[w]) begin
        free_any = 1'b1;
        free_way = WIDX_W'(w);
      end
    end
  end

  // Victim: the way with the largest stamp. The left node wins a tie, so the
  // lowest way carrying the maximum is chosen, and way 0 when all are zero.
  // Padding leaves sit on the right with a zero stamp and never win.
  logic [AGE_BITS-1:0] tree_age [TREE_LVLS+1][TREE_N];
  logic [WIDX_W-1:0]   tree_idx [TREE_LVLS+1][TREE_N];

  always_comb begin
    for (int l = 0; l <= TREE_LVLS; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        tree_age[l][i] = '0;
        tree_idx[l][i] = '0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      tree_age[0][i] = row_cur[i].age;
      tree_idx[0][i] = WIDX_W'(i);
    end
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        if (tree_age[l][2*i+1] > tree_age[l][2*i]) begin
          tree_age[l+1][i] = tree_age[l][2*i+1];
          tree_idx[l+1][i] = tree_idx[l][2*i+1];
        end else begin
          tree_age[l+1][i] = tree_age[l][2*i];
          tree_idx[l+1][i] = tree_idx[l][2*i];
        end
      end
    end
    victim_way = tree_idx[TREE_LVLS][0];
  end

  // The selected way gets stamp zero; every other valid way ages by one and
  // saturates. A hit keeps its bits and ORs in the new ones, a fill starts over.
  always_comb begin
    priority if (hit_any) begin
      sel_way = hit_way;
    end else if (free_any) begin
      sel_way = free_way;
    end else begin
      sel_way = victim_way;
    end
    acc_new = hit_any ? (row_cur[sel_way].bits | acc_set) : acc_set;
    for (int w = 0; w < WAYS; w++) begin
      new_row[w] = row_cur[w];
      vld_new[w] = vld_cur[w] || (WIDX_W'(w) == sel_way);
      if (WIDX_W'(w) == sel_way) begin
        new_row[w].tag  = s3_tag_q;
        new_row[w].age  = '0;
        new_row[w].bits = acc_new;
      end else if (vld_cur[w] && (row_cur[w].age != '1)) begin
        new_row[w].age = row_cur[w].age + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The way field carries the low bits of the way number.
  // ---------------------------------------------------------------------------
  logic                 hit_q;
  logic [WAY_OUT_W-1:0] way_q;
  logic [ACC_W-1:0]     bits_q;

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_any;
    way_q  <= WAY_OUT_W'(sel_way);
    bits_q <= acc_new;
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign way_o         = way_q;
  assign access_bits_o = bits_q;

endmodule

>>> design/satl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/satl_set_index.sv
// Two-stage reduction of a shifted address to a set index modulo SETS.
// No dependencies.
module satl_set_index #(
  parameter int SRC_W = 48,
  parameter int SETS  = 64,
  localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic             clk_i,
  input  logic [SRC_W-1:0] src_i,
  output logic [IDX_W-1:0] set_o
);

  // Residue of 2**n modulo m, by repeated doubling.
  function automatic int unsigned pow2_mod(int unsigned n, int unsigned m);
    int unsigned r;
    r = (m > 1) ? 1 : 0;
    for (int unsigned j = 0; j < n; j++) begin
      r = r << 1;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  if ((SETS & (SETS - 1)) == 0) begin : g_pow2
    logic [IDX_W-1:0] low_q;
    logic [IDX_W-1:0] set_q;

    always_ff @(posedge clk_i) begin
      low_q <= (SETS == 1) ? '0 : src_i[IDX_W-1:0];
      set_q <= low_q;
    end

    assign set_o = set_q;
  end else begin : g_mod
    localparam int SUM_W     = $clog2(SRC_W * SETS) + 1;
    localparam int RED_STEPS = $clog2(SRC_W);

    logic [SUM_W-1:0] term [SRC_W];
    logic [SUM_W-1:0] sum_d;
    logic [SUM_W-1:0] sum_q;
    logic [SUM_W-1:0] rem;
    logic [IDX_W-1:0] set_q;

    // Each address bit contributes its weight already reduced modulo SETS.
    for (genvar i = 0; i < SRC_W; i++) begin : g_term
      localparam int unsigned RESIDUE = pow2_mod(i, SETS);
      assign term[i] = src_i[i] ? SUM_W'(RESIDUE) : '0;
    end

    always_comb begin
      sum_d = '0;
      for (int i = 0; i < SRC_W; i++) begin
        sum_d = sum_d + term[i];
      end
    end

    // The sum is below SETS times a power of two, so a short chain of
    // conditional subtractions finishes the reduction.
    always_comb begin
      rem = sum_q;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
        if (rem >= (SUM_W'(SETS) << k)) begin
          rem = rem - (SUM_W'(SETS) << k);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      sum_q <= sum_d;
      set_q <= rem[IDX_W-1:0];
    end

    assign set_o = set_q;
  end

endmodule

>>> design/satl_checker.sv
// Port-level checker for the TLB lookup unit, bound to its top level.
// Depends on satl_pkg and the assertion macro header.
`include "set_assoc_tlb_lru_lookup_unit_macros.svh"

module satl_checker
  import satl_pkg::*;
#(
  parameter int VADDR_BITS = 48
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic [VADDR_BITS-1:0]   virt_addr_i,
  input logic                    is_write_i,
  input logic [PAGE_SHIFT_W-1:0] page_shift_i,
  input logic                    done_o,
  input logic                    hit_o,
  input logic [ACC_W-1:0]        access_bits_o,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o
);

  // Edges from an accepted access to the edge that sees its result.
  localparam int RESULT_DELAY = 5;

  logic acc;
  logic cfg_wr;

  assign acc    = start && !busy;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  // Every result belongs to an access accepted a fixed time earlier.
  `SATL_ASSERT_IMP(a_done_has_access, done_o, $past(acc, RESULT_DELAY), "result without access")

  // A write leaves its entry accessed and dirty, hit or fill.
  `SATL_ASSERT_DLY(a_write_dirty, acc && is_write_i, RESULT_DELAY, done_o && (access_bits_o == ACC_WRITE), "write result not dirty")

  // A read leaves its entry accessed.
  `SATL_ASSERT_DLY(a_read_accessed, acc && !is_write_i, RESULT_DELAY, done_o && access_bits_o[1], "read result not accessed")

  // The same access repeated in the next cycle hits the entry just found or
  // filled, which exercises forwarding of the last written row.
  `SATL_ASSERT_DLY(a_repeat_hits, acc ##1 (acc && $stable(virt_addr_i) && $stable(is_write_i) && $stable(page_shift_i) && !cfg_wr), RESULT_DELAY, done_o && hit_o, "repeated access missed")

endmodule

bind set_assoc_tlb_lru_lookup_unit satl_checker #(.VADDR_BITS(VADDR_BITS)) u_satl_checker (.*);
